>>> hw/rtl/lbs_pkg.sv
// shared types and constants of the skinning block
package lbs_pkg;

    localparam int MAX_JOINTS = 64;
    localparam int FRAC_BITS = 16;
    localparam int WORDS_PER_MATRIX = 12;
    localparam int TABLE_DEPTH = MAX_JOINTS * WORDS_PER_MATRIX;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int JOINT_W = 6;

    localparam logic [1:0] CMD_WORLD = 2'd0;
    localparam logic [1:0] CMD_BIND = 2'd1;
    localparam logic [1:0] CMD_INFL = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] joint_index;
        logic [3:0] matrix_element;
        logic signed [31:0] matrix_word;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic [16:0] influence_weight;
        logic last_influence;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
        logic saturated_flag;
    } out_item_t;

    // 64-bit product shifted right arithmetically (floor)
    function automatic logic signed [47:0] fshift(input logic signed [63:0] p);
        logic signed [63:0] s;
        begin
            s = p >>> FRAC_BITS;
            fshift = s[47:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        begin
            if (v > 50'sd2147483647)
                sat32 = 32'h7fffffff;
            else if (v < -50'sd2147483648)
                sat32 = 32'h80000000;
            else
                sat32 = v[31:0];
        end
    endfunction

    function automatic logic is_sat(input logic signed [49:0] v);
        begin
            is_sat = (v > 50'sd2147483647) || (v < -50'sd2147483648);
        end
    endfunction

endpackage

>>> hw/rtl/linear_blend_skinning.sv
// linear blend skinning top level: sequencer over the two matrix tables
// write beats may follow back to back
// an influence beat keeps the input stalled through binding pass, world pass,
// weighting and accumulate; a last influence offers its vertex result after accumulate
// a result held by the receiver stalls the input until it is taken
// reset clears sums, saturation mark and handshake state; tables undefined until written
module linear_blend_skinning (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  lbs_pkg::in_item_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output lbs_pkg::out_item_t out_data
);
    import lbs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_BIND, S_WORLD, S_WEIGHT, S_ACC} state_t;

    state_t state_reg;
    in_item_t item_reg;
    logic [3:0] cnt_reg;
    logic [3:0] ph_reg;
    logic signed [31:0] vin_reg [3];
    logic signed [31:0] vout_reg [3];
    logic signed [31:0] sum_reg [3];
    logic sat_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic accept;
    logic [ADDR_W-1:0] base, waddr, raddr;
    logic signed [31:0] wrd_b, wrd_w, mword;
    logic signed [31:0] mac_a;
    logic signed [32:0] mac_b;
    logic signed [47:0] prod;
    logic wr_ok;
    logic [1:0] col;
    logic acc_hold;

    // row of a matrix word: element is col*3+row
    function automatic logic [1:0] elem_row(input logic [3:0] e);
        logic [1:0] r;
        begin
            if (e < 4'd3)
                r = 2'(e);
            else if (e < 4'd6)
                r = 2'(e - 4'd3);
            else if (e < 4'd9)
                r = 2'(e - 4'd6);
            else
                r = 2'(e - 4'd9);
            elem_row = r;
        end
    endfunction

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // a last influence waits in accumulate while the result register is still held
    assign acc_hold = item_reg.last_influence && out_valid_reg && out_stall;

    assign wr_ok = accept && (in_data.matrix_element < 4'd12);
    assign waddr = ADDR_W'(in_data.joint_index * WORDS_PER_MATRIX + in_data.matrix_element);
    assign base = ADDR_W'(item_reg.joint_index * WORDS_PER_MATRIX);
    assign raddr = ADDR_W'(base + ((cnt_reg < 4'd12) ? cnt_reg : 4'd0));

    lbs_table u_bind (.clk(clk), .we(wr_ok && in_data.cmd == CMD_BIND), .waddr(waddr),
        .wdata(in_data.matrix_word), .raddr(raddr), .rdata(wrd_b));
    lbs_table u_world (.clk(clk), .we(wr_ok && in_data.cmd == CMD_WORLD), .waddr(waddr),
        .wdata(in_data.matrix_word), .raddr(raddr), .rdata(wrd_w));

    assign mword = (state_reg == S_BIND) ? wrd_b : wrd_w;

    // ph_reg is the element whose memory word is now on rdata (ph_reg is cnt_reg registered)
    always_comb
    begin
        if (ph_reg < 4'd3)
            col = 2'd0;
        else if (ph_reg < 4'd6)
            col = 2'd1;
        else
            col = 2'd2;
        mac_a = mword;
        mac_b = {vin_reg[col][31], vin_reg[col]};
        if (state_reg == S_WEIGHT)
        begin
            mac_a = vout_reg[(cnt_reg[1:0] == 2'd3) ? 2'd2 : cnt_reg[1:0]];
            mac_b = {16'd0, item_reg.influence_weight};
        end
    end

    lbs_mac u_mac (.clk(clk), .a(mac_a), .b(mac_b), .prod(prod));

    // rows walk x,y,z for each column; products arrive in the cycle after issue
    logic mv_reg;
    logic [3:0] pe_reg;
    logic signed [49:0] racc [3];
    logic signed [49:0] nv;
    logic [1:0] prow;

    always_comb
    begin
        prow = elem_row(pe_reg);
        nv = racc[prow] + 50'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            ph_reg <= '0;
            pe_reg <= '0;
            mv_reg <= 1'b0;
            sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            if (state_reg == S_ACC && item_reg.last_influence && !acc_hold)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            mv_reg <= ((state_reg == S_BIND) || (state_reg == S_WORLD)) &&
                      (cnt_reg != 4'd0) && (ph_reg < 4'd9);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_data.cmd == CMD_INFL)
                    begin
                        item_reg <= in_data;
                        vin_reg[0] <= in_data.position_x;
                        vin_reg[1] <= in_data.position_y;
                        vin_reg[2] <= in_data.position_z;
                        cnt_reg <= '0;
                        if (in_data.joint_index < JOINT_W'(MAX_JOINTS % 64) ||
                            MAX_JOINTS >= 64)
                            state_reg <= S_BIND;
                        else
                            state_reg <= S_ACC;
                        for (int i = 0; i < 3; i++)
                            vout_reg[i] <= '0;
                    end
                end
                S_BIND, S_WORLD:
                begin
                    // cnt 0..13: cnt k issues read k (k < 12) and uses word k-1: multiplies 0..8, adds 9..11
                    if (cnt_reg == 4'd0)
                        for (int i = 0; i < 3; i++)
                            racc[i] <= '0;
                    if (cnt_reg != 4'd0)
                    begin
                        if (ph_reg < 4'd9)
                            pe_reg <= ph_reg;
                        else if (ph_reg < 4'd12)
                            racc[elem_row(ph_reg)] <= racc[elem_row(ph_reg)] + 50'(mword);
                    end
                    if (mv_reg)
                        racc[prow] <= nv;
                    ph_reg <= cnt_reg;
                    if (cnt_reg == 4'd13)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            vin_reg[i] <= sat32(racc[i]);
                            vout_reg[i] <= sat32(racc[i]);
                        end
                        if (is_sat(racc[0]) || is_sat(racc[1]) || is_sat(racc[2]))
                            sat_reg <= 1'b1;
                        cnt_reg <= '0;
                        state_reg <= (state_reg == S_BIND) ? S_WORLD : S_WEIGHT;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                S_WEIGHT:
                begin
                    // cnt 0..2 issue, 1..3 collect
                    if (cnt_reg != 4'd0)
                    begin
                        vout_reg[2'(cnt_reg - 4'd1)] <= sat32(50'(prod));
                        if (is_sat(50'(prod)))
                            sat_reg <= 1'b1;
                    end
                    if (cnt_reg == 4'd3)
                        state_reg <= S_ACC;
                    cnt_reg <= cnt_reg + 4'd1;
                end
                S_ACC:
                begin
                    logic signed [31:0] s [3];
                    logic any;
                    any = sat_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        s[i] = sat32(50'(sum_reg[i]) + 50'(vout_reg[i]));
                        if (is_sat(50'(sum_reg[i]) + 50'(vout_reg[i])))
                            any = 1'b1;
                    end
                    if (!acc_hold)
                    begin
                        if (item_reg.last_influence)
                        begin
                            out_reg.skinned_x <= s[0];
                            out_reg.skinned_y <= s[1];
                            out_reg.skinned_z <= s[2];
                            out_reg.saturated_flag <= any;
                            for (int i = 0; i < 3; i++)
                                sum_reg[i] <= '0;
                            sat_reg <= 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                sum_reg[i] <= s[i];
                            sat_reg <= any;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/lbs_table.sv
// matrix word memory, one write and one registered read per cycle
module lbs_table (
    input  logic clk,
    input  logic we,
    input  logic [lbs_pkg::ADDR_W-1:0] waddr,
    input  logic signed [31:0] wdata,
    input  logic [lbs_pkg::ADDR_W-1:0] raddr,
    output logic signed [31:0] rdata
);
    import lbs_pkg::*;

    logic signed [31:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/lbs_mac.sv
// one multiply per cycle with floor shift, registered product
module lbs_mac (
    input  logic clk,
    input  logic signed [31:0] a,
    input  logic signed [32:0] b,
    output logic signed [47:0] prod
);
    import lbs_pkg::*;

    logic signed [64:0] full;

    always_comb
    begin
        full = a * b;
    end

    always_ff @(posedge clk)
    begin
        prod <= fshift(full[63:0]);
    end
endmodule
